// File: hdl/urptc_pkg.sv
// Shared types, control codes and helpers for the URP receive core.
package urptc_pkg;

  localparam int MAX_MESSAGE_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] C_SEQ     = 8'o010;
  localparam logic [7:0] C_ECHO    = 8'o020;
  localparam logic [7:0] C_REJ     = 8'o030;
  localparam logic [7:0] C_ACK     = 8'o040;
  localparam logic [7:0] C_BOT     = 8'o050;
  localparam logic [7:0] C_BOTM    = 8'o051;
  localparam logic [7:0] C_BOTS    = 8'o052;
  localparam logic [7:0] C_ENQ     = 8'o055;
  localparam logic [7:0] C_CHECK   = 8'o056;
  localparam logic [7:0] C_INITREQ = 8'o057;
  localparam logic [7:0] C_INIT0   = 8'o060;
  localparam logic [7:0] C_INIT1   = 8'o061;
  localparam logic [7:0] C_AINIT   = 8'o062;
  localparam logic [7:0] C_BREAK   = 8'o110;
  localparam logic [7:0] TOP_MASK  = 8'o370;
  localparam logic [7:0] CTRL_HIGH = 8'o200;

  localparam logic [2:0] KIND_STAGE   = 3'd0;
  localparam logic [2:0] KIND_COMMIT  = 3'd1;
  localparam logic [2:0] KIND_DISCARD = 3'd2;
  localparam logic [2:0] KIND_SEND    = 3'd3;
  localparam logic [2:0] KIND_CTRL_UP = 3'd4;
  localparam logic [2:0] KIND_ACK_TX  = 3'd5;
  localparam logic [2:0] KIND_WRESET  = 3'd6;
  localparam logic [2:0] KIND_DATA_UP = 3'd7;

  localparam logic [1:0] RSN_NONE       = 2'd0;
  localparam logic [1:0] RSN_NO_TRAILER = 2'd1;
  localparam logic [1:0] RSN_BAD_SEQ    = 2'd2;
  localparam logic [1:0] RSN_BAD_LEN    = 2'd3;

  typedef struct packed {
    logic       is_control;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_value;
    logic       delimit;
    logic [1:0] reject_reason;
    logic       char_mode_now;
    logic       link_open;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]           count;
    out_item_t [2:0]      res;
  } bundle_t;

  function automatic out_item_t mk_res(logic [2:0] kind, logic [7:0] b, logic d,
                                       logic [1:0] r);
    out_item_t t;
    t = '0;
    t.kind = kind;
    t.byte_value = b;
    t.delimit = d;
    t.reject_reason = r;
    return t;
  endfunction

endpackage

// File: hdl/urptc_front.sv
// Front end: accepts link bytes, updates protocol state, builds result bundles.
module urptc_front #(
  parameter int MAX_MESSAGE = urptc_pkg::MAX_MESSAGE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_data,
  input  logic               take,
  input  urptc_pkg::in_item_t item,
  output logic               push,
  output urptc_pkg::bundle_t bundle
);
  import urptc_pkg::*;

  localparam int CNT_W = $clog2(MAX_MESSAGE + 2);
  localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_MESSAGE);

  logic             xmit_r;
  logic             rx_char_r, rx_char_nxt;
  logic             opened_r, opened_nxt;
  logic             rec_delim_r, rec_delim_nxt;
  logic [1:0]       tidx_r, tidx_nxt;
  logic [7:0]       tb0_r, tb0_nxt, tb1_r, tb1_nxt, tb2_r, tb2_nxt;
  logic [CNT_W-1:0] staged_r, staged_nxt;
  logic [2:0]       eps_r, eps_nxt;
  logic [7:0]       les_r, les_nxt;

  logic [7:0]       v;
  logic [2:0]       sq;
  logic [2:0]       eps_rej;
  logic [1:0]       n;
  logic [1:0]       reason;
  logic [15:0]      len;
  logic [CNT_W-1:0] bumped;
  out_item_t [2:0]  res;

  assign v      = item.value;
  assign sq     = v[2:0];
  assign len    = {tb2_r, tb1_r};
  assign bumped = (staged_r <= LIMIT) ? staged_r + 1'b1 : staged_r;

  always_comb begin
    if (tidx_r != 2'd3) begin
      reason = RSN_NO_TRAILER;
    end else if (sq != eps_r + 3'd1) begin
      reason = RSN_BAD_SEQ;
    end else if (CMP_W'(staged_r) != CMP_W'(len)) begin
      reason = RSN_BAD_LEN;
    end else begin
      reason = RSN_NONE;
    end
    eps_rej = (tb0_r == C_BOTS) ? sq : eps_r;
  end

  always_comb begin
    rx_char_nxt   = rx_char_r;
    opened_nxt    = opened_r;
    rec_delim_nxt = rec_delim_r;
    tidx_nxt      = tidx_r;
    tb0_nxt       = tb0_r;
    tb1_nxt       = tb1_r;
    tb2_nxt       = tb2_r;
    staged_nxt    = staged_r;
    eps_nxt       = eps_r;
    les_nxt       = les_r;
    n             = 2'd0;
    res           = '0;
    if (item.is_control) begin
      if (v == C_ENQ || v == C_CHECK) begin
        staged_nxt = '0;
        tidx_nxt   = 2'd0;
        if (v == C_ENQ) begin
          res[0] = mk_res(KIND_SEND, les_r, 1'b0, RSN_NONE);
          res[1] = mk_res(KIND_SEND, C_ACK + {5'd0, eps_r}, 1'b0, RSN_NONE);
          res[2] = mk_res(KIND_DISCARD, 8'd0, 1'b0, RSN_NONE);
          n      = 2'd3;
        end else begin
          res[0] = mk_res(KIND_SEND, C_ACK + {5'd0, eps_r}, 1'b0, RSN_NONE);
          res[1] = mk_res(KIND_DISCARD, 8'd0, 1'b0, RSN_NONE);
          n      = 2'd2;
        end
      end else if (v == C_AINIT) begin
        opened_nxt = 1'b1;
        staged_nxt = '0;
        tidx_nxt   = 2'd0;
        res[0]     = mk_res(KIND_DISCARD, 8'd0, 1'b0, RSN_NONE);
        n          = 2'd1;
      end else if (v == C_INIT0 || v == C_INIT1) begin
        if (v == C_INIT0 && !rx_char_r) begin
          rx_char_nxt   = 1'b1;
          rec_delim_nxt = 1'b0;
        end else if (v == C_INIT1 && rx_char_r) begin
          rx_char_nxt   = 1'b0;
          rec_delim_nxt = 1'b1;
        end
        staged_nxt = '0;
        tidx_nxt   = 2'd0;
        eps_nxt    = 3'd0;
        res[0]     = mk_res(KIND_SEND, C_AINIT, 1'b0, RSN_NONE);
        res[1]     = mk_res(KIND_DISCARD, 8'd0, 1'b0, RSN_NONE);
        n          = 2'd2;
      end else if (v == C_INITREQ) begin
        staged_nxt = '0;
        tidx_nxt   = 2'd0;
        if (xmit_r) begin
          res[0] = mk_res(KIND_SEND, C_INIT0, 1'b0, RSN_NONE);
          res[1] = mk_res(KIND_DISCARD, 8'd0, 1'b0, RSN_NONE);
          n      = 2'd2;
        end else begin
          res[0] = mk_res(KIND_WRESET, 8'd0, 1'b0, RSN_NONE);
          res[1] = mk_res(KIND_SEND, C_INIT1, 1'b0, RSN_NONE);
          res[2] = mk_res(KIND_DISCARD, 8'd0, 1'b0, RSN_NONE);
          n      = 2'd3;
        end
      end else if (v == C_BREAK) begin
        staged_nxt = bumped;
        res[0]     = mk_res(KIND_CTRL_UP, v, 1'b0, RSN_NONE);
        n          = 2'd1;
      end else if (v == C_BOT || v == C_BOTM || v == C_BOTS) begin
        tidx_nxt = 2'd1;
        tb0_nxt  = v;
      end else if ((v & TOP_MASK) == C_REJ) begin
        if (!xmit_r) begin
          res[0] = mk_res(KIND_ACK_TX, v, 1'b0, RSN_NONE);
          n      = 2'd1;
        end
      end else if ((v & TOP_MASK) == C_ACK || (v & TOP_MASK) == C_ECHO) begin
        res[0] = mk_res(KIND_ACK_TX, v, 1'b0, RSN_NONE);
        n      = 2'd1;
      end else if ((v & TOP_MASK) == C_SEQ) begin
        if (rx_char_r) begin
          les_nxt = C_ECHO + {5'd0, sq};
          res[0]  = mk_res(KIND_SEND, C_ECHO + {5'd0, sq}, 1'b0, RSN_NONE);
          n       = 2'd1;
        end else if (reason != RSN_NONE) begin
          staged_nxt = '0;
          tidx_nxt   = 2'd0;
          eps_nxt    = eps_rej;
          les_nxt    = C_REJ + {5'd0, eps_rej};
          res[0]     = mk_res(KIND_DISCARD, 8'd0, 1'b0, reason);
          res[1]     = mk_res(KIND_SEND, C_REJ + {5'd0, eps_rej}, 1'b0, reason);
          n          = 2'd2;
        end else begin
          staged_nxt = '0;
          tidx_nxt   = 2'd0;
          eps_nxt    = sq;
          les_nxt    = C_ECHO + {5'd0, sq};
          res[0]     = mk_res(KIND_COMMIT, 8'd0, (tb0_r != C_BOTM) && rec_delim_r,
                              RSN_NONE);
          res[1]     = mk_res(KIND_SEND, C_ECHO + {5'd0, sq}, 1'b0, RSN_NONE);
          n          = 2'd2;
        end
      end else begin
        if (v < CTRL_HIGH) begin
          staged_nxt = bumped;
        end
        res[0] = mk_res(KIND_CTRL_UP, v, 1'b0, RSN_NONE);
        n      = 2'd1;
      end
    end else begin
      if (rx_char_r) begin
        res[0] = mk_res(KIND_DATA_UP, v, 1'b0, RSN_NONE);
        n      = 2'd1;
      end else if (tidx_r == 2'd1) begin
        tb1_nxt  = v;
        tidx_nxt = 2'd2;
      end else if (tidx_r == 2'd2) begin
        tb2_nxt  = v;
        tidx_nxt = 2'd3;
      end else begin
        tidx_nxt = 2'd0;
        if (staged_r <= LIMIT) begin
          staged_nxt = bumped;
          res[0]     = mk_res(KIND_STAGE, v, 1'b0, RSN_NONE);
          n          = 2'd1;
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      res[k].char_mode_now = rx_char_nxt;
      res[k].link_open     = opened_nxt | xmit_r;
      res[k].last          = (2'(k) == n - 2'd1);
    end
  end

  assign push         = take && (n != 2'd0);
  assign bundle.count = n;
  assign bundle.res   = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xmit_r      <= 1'b0;
      rx_char_r   <= 1'b1;
      opened_r    <= 1'b0;
      rec_delim_r <= 1'b0;
      tidx_r      <= 2'd0;
      tb0_r       <= 8'd0;
      tb1_r       <= 8'd0;
      tb2_r       <= 8'd0;
      staged_r    <= '0;
      eps_r       <= 3'd0;
      les_r       <= C_ECHO;
    end else begin
      if (cfg_we) begin
        xmit_r <= cfg_data;
      end
      if (take) begin
        rx_char_r   <= rx_char_nxt;
        opened_r    <= opened_nxt;
        rec_delim_r <= rec_delim_nxt;
        tidx_r      <= tidx_nxt;
        tb0_r       <= tb0_nxt;
        tb1_r       <= tb1_nxt;
        tb2_r       <= tb2_nxt;
        staged_r    <= staged_nxt;
        eps_r       <= eps_nxt;
        les_r       <= les_nxt;
      end
    end
  end

endmodule

// File: hdl/urptc_queue.sv
// Short register queue of result bundles between front and back end.
module urptc_queue #(
  parameter int DEPTH = urptc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  urptc_pkg::bundle_t wdata,
  input  logic               pop,
  output logic               full,
  output logic               empty,
  output urptc_pkg::bundle_t head
);
  import urptc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// File: hdl/urptc_back.sv
// Back end: walks each queued bundle and issues its results one per cycle while out_stall is low.
module urptc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 empty,
  input  urptc_pkg::bundle_t   head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output urptc_pkg::out_item_t out_item
);
  import urptc_pkg::*;

  logic       valid_r, valid_nxt;
  out_item_t  item_r;
  logic [1:0] idx_r, idx_nxt;
  logic       load;

  assign load = !empty && (!valid_r || !out_stall);
  assign pop  = load && (idx_r == head.count - 2'd1);

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = pop ? 2'd0 : idx_r + 2'd1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= head.res[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// File: hdl/urp_receiver_trailer_check_core.sv
// URP receive core: takes one link byte per cycle while the result queue has room.
// Accepted bytes are classified and applied to the receive state in the cycle they
// are taken; their zero to three results enter a four-bundle queue and leave through
// a registered output, one result per cycle while the consumer does not stall.
// Several results of one byte hold the queue head until the last leaves, so the input
// stalls only when the queue fills, behind a stalled result consumer or a run of
// bytes that each give several results.
module urp_receiver_trailer_check_core #(
  parameter int MAX_MESSAGE = urptc_pkg::MAX_MESSAGE_DEF,
  parameter int QUEUE_DEPTH = urptc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  urptc_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output urptc_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);
  import urptc_pkg::*;

  logic    take, push, pop, full, empty;
  bundle_t bundle, head;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign take      = in_valid && !full;

  urptc_front #(.MAX_MESSAGE(MAX_MESSAGE)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .take     (take),
    .item     (in_item),
    .push     (push),
    .bundle   (bundle)
  );

  urptc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (bundle),
    .pop   (pop),
    .full  (full),
    .empty (empty),
    .head  (head)
  );

  urptc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: hdl/urptc_checker.sv
// Port-level checks on the URP receive core and their bind to the top level.
module urptc_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input urptc_pkg::out_item_t out_item
);
  import urptc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_reject_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == KIND_DISCARD && out_item.reject_reason != RSN_NONE
    |-> !out_item.last)
    else $error("reject discard not followed by reject send");

  a_delim_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind != KIND_COMMIT |-> !out_item.delimit)
    else $error("delimit outside commit");

  a_reason_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.reject_reason != RSN_NONE
    |-> out_item.kind == KIND_DISCARD || out_item.kind == KIND_SEND)
    else $error("reject reason on wrong kind");

endmodule

bind urp_receiver_trailer_check_core urptc_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// File: tb/tb.sv
// Self-checking testbench for the URP receive core: link bytes in, predicted results out.
module tb;
  import urptc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int TAIL_CYCLES  = 10;

  typedef struct packed {
    logic            rx_char;
    logic            opened;
    logic            rec_delim;
    logic [1:0]      trl_idx;
    logic [2:0][7:0] trl;
    logic [12:0]     staged;
    logic [2:0]      prev_seq;
    logic [7:0]      last_echo;
  } link_state_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  in_item_t    link_bytes[$];
  out_item_t   due_results[$];
  link_state_t link_st;
  link_state_t plan_st;
  logic        xmit_char = 1'b0;
  logic        in_took   = 1'b0;
  int          snd_idle  = 0;
  int          rcv_idle  = 0;
  int          errors    = 0;
  int          cycles    = 0;
  int          planned   = 0;

  urp_receiver_trailer_check_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic out_item_t rx_result(logic [2:0] kind, logic [7:0] b, logic d,
                                          logic [1:0] why);
    out_item_t t;
    t = '0;
    t.kind = kind;
    t.byte_value = b;
    t.delimit = d;
    t.reject_reason = why;
    return t;
  endfunction

  function automatic string show(out_item_t t);
    return $sformatf("kind %0d byte %h delim %0d reason %0d char %0d open %0d last %0d",
                     t.kind, t.byte_value, t.delimit, t.reject_reason, t.char_mode_now,
                     t.link_open, t.last);
  endfunction

  // Apply one link byte to the receive state and return the results it causes.
  function automatic int link_step(inout link_state_t s, input logic xmit, input in_item_t it,
                                   output out_item_t [2:0] r);
    int          n;
    logic        flush_now;
    logic [7:0]  v;
    logic [7:0]  top;
    logic [2:0]  sn;
    logic [2:0]  want;
    logic [15:0] len;
    logic [1:0]  why;
    n = 0;
    flush_now = 1'b0;
    r = '0;
    v = it.value;
    top = v & TOP_MASK;
    if (!it.is_control) begin
      if (s.rx_char) begin
        r[n] = rx_result(KIND_DATA_UP, v, 1'b0, RSN_NONE);
        n++;
      end else if (s.trl_idx == 2'd1 || s.trl_idx == 2'd2) begin
        s.trl[s.trl_idx] = v;
        s.trl_idx++;
      end else begin
        s.trl_idx = 2'd0;
        if (s.staged <= MAX_MESSAGE_DEF) begin
          s.staged++;
          r[n] = rx_result(KIND_STAGE, v, 1'b0, RSN_NONE);
          n++;
        end
      end
    end else if (v == C_ENQ || v == C_CHECK) begin
      if (v == C_ENQ) begin
        r[n] = rx_result(KIND_SEND, s.last_echo, 1'b0, RSN_NONE);
        n++;
      end
      r[n] = rx_result(KIND_SEND, C_ACK + {5'b0, s.prev_seq}, 1'b0, RSN_NONE);
      n++;
      flush_now = 1'b1;
    end else if (v == C_AINIT) begin
      s.opened = 1'b1;
      flush_now = 1'b1;
    end else if (v == C_INIT0 || v == C_INIT1) begin
      r[n] = rx_result(KIND_SEND, C_AINIT, 1'b0, RSN_NONE);
      n++;
      if (v == C_INIT0 && !s.rx_char) begin
        s.rx_char = 1'b1;
        s.rec_delim = 1'b0;
      end else if (v == C_INIT1 && s.rx_char) begin
        s.rx_char = 1'b0;
        s.rec_delim = 1'b1;
      end
      s.prev_seq = 3'd0;
      flush_now = 1'b1;
    end else if (v == C_INITREQ) begin
      if (xmit) begin
        r[n] = rx_result(KIND_SEND, C_INIT0, 1'b0, RSN_NONE);
        n++;
      end else begin
        r[n] = rx_result(KIND_WRESET, 8'd0, 1'b0, RSN_NONE);
        n++;
        r[n] = rx_result(KIND_SEND, C_INIT1, 1'b0, RSN_NONE);
        n++;
      end
      flush_now = 1'b1;
    end else if (v == C_BREAK) begin
      if (s.staged <= MAX_MESSAGE_DEF) s.staged++;
      r[n] = rx_result(KIND_CTRL_UP, v, 1'b0, RSN_NONE);
      n++;
    end else if (v == C_BOT || v == C_BOTM || v == C_BOTS) begin
      s.trl_idx = 2'd1;
      s.trl[0] = v;
    end else if (top == C_REJ) begin
      if (!xmit) begin
        r[n] = rx_result(KIND_ACK_TX, v, 1'b0, RSN_NONE);
        n++;
      end
    end else if (top == C_ACK || top == C_ECHO) begin
      r[n] = rx_result(KIND_ACK_TX, v, 1'b0, RSN_NONE);
      n++;
    end else if (top == C_SEQ) begin
      sn = v[2:0];
      want = s.prev_seq + 3'd1;
      if (s.rx_char) begin
        s.last_echo = C_ECHO + {5'b0, sn};
        r[n] = rx_result(KIND_SEND, s.last_echo, 1'b0, RSN_NONE);
        n++;
      end else begin
        len = {s.trl[2], s.trl[1]};
        if (s.trl_idx != 2'd3) why = RSN_NO_TRAILER;
        else if (sn != want) why = RSN_BAD_SEQ;
        else if ({3'b0, s.staged} != len) why = RSN_BAD_LEN;
        else why = RSN_NONE;
        s.staged = '0;
        s.trl_idx = 2'd0;
        if (why != RSN_NONE) begin
          r[n] = rx_result(KIND_DISCARD, 8'd0, 1'b0, why);
          n++;
          if (s.trl[0] == C_BOTS) s.prev_seq = sn;
          s.last_echo = C_REJ + {5'b0, s.prev_seq};
          r[n] = rx_result(KIND_SEND, s.last_echo, 1'b0, why);
          n++;
        end else begin
          r[n] = rx_result(KIND_COMMIT, 8'd0, (s.trl[0] != C_BOTM) && s.rec_delim, RSN_NONE);
          n++;
          s.prev_seq = sn;
          s.last_echo = C_ECHO + {5'b0, sn};
          r[n] = rx_result(KIND_SEND, s.last_echo, 1'b0, RSN_NONE);
          n++;
        end
      end
    end else begin
      if (v < CTRL_HIGH && s.staged <= MAX_MESSAGE_DEF) s.staged++;
      r[n] = rx_result(KIND_CTRL_UP, v, 1'b0, RSN_NONE);
      n++;
    end
    if (flush_now) begin
      s.staged = '0;
      s.trl_idx = 2'd0;
      r[n] = rx_result(KIND_DISCARD, 8'd0, 1'b0, RSN_NONE);
      n++;
    end
    for (int k = 0; k < n; k++) begin
      r[k].char_mode_now = s.rx_char;
      r[k].link_open = s.opened | xmit;
      r[k].last = (k == n - 1);
    end
    return n;
  endfunction

  task automatic add_byte(input logic ctrl, input logic [7:0] v);
    in_item_t        it;
    out_item_t [2:0] scratch;
    it.is_control = ctrl;
    it.value = v;
    link_bytes.push_back(it);
    void'(link_step(plan_st, xmit_char, it, scratch));
    planned++;
  endtask

  // Stage a block, close it with a trailer and a SEQ; optionally break one part of it.
  task automatic send_block(input int len, input logic faulty);
    int          f;
    logic [15:0] cnt;
    logic [2:0]  sn;
    f = faulty ? $urandom_range(19) : 19;
    if (plan_st.rx_char) add_byte(1'b1, C_INIT1);
    repeat (len) add_byte(1'b0, 8'($urandom_range(255)));
    if (f != 0) begin
      case ($urandom_range(2))
        0: add_byte(1'b1, C_BOT);
        1: add_byte(1'b1, C_BOTM);
        default: add_byte(1'b1, C_BOTS);
      endcase
      cnt = {3'b0, plan_st.staged};
      if (f == 1) cnt = cnt + 16'($urandom_range(1, 3));
      if (f == 2) cnt = cnt ^ 16'hFF00;
      add_byte(1'b0, cnt[7:0]);
      add_byte(1'b0, cnt[15:8]);
      if (f == 4) add_byte(1'b0, 8'($urandom_range(255)));
    end
    sn = plan_st.prev_seq + 3'd1;
    if (f == 3) sn = sn + 3'($urandom_range(1, 7));
    add_byte(1'b1, C_SEQ + {5'b0, sn});
  endtask

  task automatic drain();
    while (link_bytes.size() != 0 || due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    xmit_char = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_idle);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_took) link_bytes.delete(0);
      if (!(in_valid && !in_took)) begin
        if (link_bytes.size() != 0 && $urandom_range(99) >= snd_idle) begin
          in_valid <= 1'b1;
          in_item <= link_bytes[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t       want_r;
    out_item_t [2:0] fresh;
    int              n;
    in_took = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %s", $time, show(out_item));
        errors++;
      end else begin
        want_r = due_results.pop_front();
        if (out_item !== want_r) begin
          $display("%0t: result mismatch, expected %s, got %s", $time, show(want_r),
                   show(out_item));
          errors++;
        end
      end
    end
    if (in_took) begin
      n = link_step(link_st, xmit_char, in_item, fresh);
      for (int k = 0; k < n; k++) due_results.push_back(fresh[k]);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int         mark;
    int         pick;
    logic [7:0] code;
    link_st = '0;
    link_st.rx_char = 1'b1;
    link_st.last_echo = C_ECHO;
    plan_st = link_st;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_cfg(1'b0);
    snd_idle = 19;
    rcv_idle = 63;

    add_byte(1'b0, 8'h00);
    add_byte(1'b0, 8'hFF);
    add_byte(1'b1, C_SEQ + 8'd3);
    add_byte(1'b1, C_ENQ);
    add_byte(1'b1, C_CHECK);
    add_byte(1'b1, C_AINIT);
    add_byte(1'b1, C_INITREQ);
    add_byte(1'b1, C_INIT1);
    add_byte(1'b0, 8'h5A);
    add_byte(1'b1, C_BREAK);
    add_byte(1'b1, 8'hFF);
    add_byte(1'b1, C_BOTS);
    add_byte(1'b0, 8'd2);
    add_byte(1'b0, 8'd0);
    add_byte(1'b1, C_SEQ + 8'd1);
    add_byte(1'b1, C_ACK + 8'd5);
    add_byte(1'b1, C_ECHO + 8'd2);
    add_byte(1'b1, C_REJ + 8'd7);
    add_byte(1'b1, C_SEQ + 8'd5);
    add_byte(1'b1, C_BOT);
    add_byte(1'b0, 8'd1);
    add_byte(1'b0, 8'd0);
    add_byte(1'b1, C_SEQ + 8'd6);
    add_byte(1'b1, C_BOTM);
    add_byte(1'b0, 8'd0);
    add_byte(1'b0, 8'd0);
    add_byte(1'b1, C_SEQ + 8'd0);
    add_byte(1'b1, C_INIT0);
    drain();

    for (int seg = 0; seg < 6; seg++) begin
      write_cfg(seg % 2 == 0);
      snd_idle = (seg < 2) ? 19 : (seg < 4) ? 63 : 0;
      rcv_idle = (seg < 2) ? 63 : (seg < 4) ? 19 : 0;
      mark = planned;
      while (planned - mark < 63) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          case ($urandom_range(3))
            0: add_byte(1'($urandom_range(1)), 8'($urandom_range(255)));
            1: begin
              case ($urandom_range(6))
                0: code = C_ENQ;
                1: code = C_CHECK;
                2: code = C_AINIT;
                3: code = C_INITREQ;
                4: code = C_INIT0;
                5: code = C_INIT1;
                default: code = C_BREAK;
              endcase
              add_byte(1'b1, code);
            end
            2: begin
              case ($urandom_range(2))
                0: code = C_ACK;
                1: code = C_ECHO;
                default: code = C_REJ;
              endcase
              add_byte(1'b1, code + 8'($urandom_range(7)));
            end
            default: add_byte(1'b0, 8'($urandom_range(255)));
          endcase
        end else if (pick < 35) begin
          if (!plan_st.rx_char) add_byte(1'b1, C_INIT0);
          repeat ($urandom_range(4)) add_byte(1'b0, 8'($urandom_range(255)));
          add_byte(1'b1, C_SEQ + 8'($urandom_range(7)));
        end else begin
          send_block($urandom_range(6), 1'b1);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
